### sv/dibc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dibc_pkg
// shared types and constants of the display idle blank controller
// ----------------------------------------------------------------------------
package dibc_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int LEVEL_W    = 8;

	localparam logic [LEVEL_W-1:0] DIM_LEVEL     = 8'd5;
	localparam logic [LEVEL_W-1:0] OFF_LEVEL     = 8'd0;
	localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL = 8'd255;
	localparam int                 DIM_LEAD      = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLEEP_SECONDS = 2'd0,
		CFG_BRIGHT_FILE   = 2'd1,
		CFG_MAX_BRIGHT    = 2'd2,
		CFG_PANEL_BLANK   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_ACTIVITY = 2'd1,
		MODE_BLANK    = 2'd2,
		MODE_TOGGLE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PANEL_NONE    = 2'd0,
		PANEL_BLANK   = 2'd1,
		PANEL_UNBLANK = 2'd2
	} panel_cmd_t;

	typedef enum logic [3:0] {
		SCR_ON      = 4'b0001,
		SCR_DIM     = 4'b0010,
		SCR_OFF     = 4'b0100,
		SCR_BLANKED = 4'b1000
	} scr_state_t;

	localparam logic [1:0] CODE_ON      = 2'd0;
	localparam logic [1:0] CODE_DIM     = 2'd1;
	localparam logic [1:0] CODE_OFF     = 2'd2;
	localparam logic [1:0] CODE_BLANKED = 2'd3;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] sleep_seconds;
		logic                  brightness_file_present;
		logic [LEVEL_W-1:0]    max_brightness;
		logic                  panel_blank_enable;
	} cfg_t;

	typedef struct packed {
		mode_t              mode;
		logic [LEVEL_W-1:0] setting_brightness;
		logic               setting_present;
	} item_t;

	typedef struct packed {
		logic [1:0]         display_state;
		logic               screen_off;
		logic               brightness_write;
		logic [LEVEL_W-1:0] brightness_value;
		panel_cmd_t         panel_cmd;
		logic               run_blank_hook;
		logic               run_unblank_hook;
		logic               show_lock;
		logic               force_redraw;
	} result_t;

	function automatic logic [1:0] state_code(input scr_state_t st);
		logic [1:0] code;
		case (st)
			SCR_ON:      code = CODE_ON;
			SCR_DIM:     code = CODE_DIM;
			SCR_OFF:     code = CODE_OFF;
			SCR_BLANKED: code = CODE_BLANKED;
			default:     code = CODE_ON;
		endcase
		return code;
	endfunction

endpackage

### sv/dibc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dibc_in_if / dibc_out_if
// valid/ready channels for event words and result words
// ----------------------------------------------------------------------------
interface dibc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] setting_brightness;
	logic       setting_present;

	modport source (output valid, mode, setting_brightness, setting_present, input ready);
	modport sink   (input valid, mode, setting_brightness, setting_present, output ready);
endinterface

interface dibc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] display_state;
	logic       screen_off;
	logic       brightness_write;
	logic [7:0] brightness_value;
	logic [1:0] panel_cmd;
	logic       run_blank_hook;
	logic       run_unblank_hook;
	logic       show_lock;
	logic       force_redraw;

	modport source (
		output valid, display_state, screen_off, brightness_write, brightness_value,
		       panel_cmd, run_blank_hook, run_unblank_hook, show_lock, force_redraw,
		input  ready
	);
	modport sink (
		input  valid, display_state, screen_off, brightness_write, brightness_value,
		       panel_cmd, run_blank_hook, run_unblank_hook, show_lock, force_redraw,
		output ready
	);
endinterface

### sv/dibc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dibc_cfg
// configuration register file, written through a plain indexed write port
// ----------------------------------------------------------------------------
module dibc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dibc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dibc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dibc_pkg::cfg_t                   cfg
);

	dibc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sleep_seconds           <= '0;
			cfg_q.brightness_file_present <= 1'b1;
			cfg_q.max_brightness          <= dibc_pkg::DEFAULT_LEVEL;
			cfg_q.panel_blank_enable      <= 1'b1;
		end else if (cfg_we) begin
			case (dibc_pkg::cfg_idx_t'(cfg_index))
				dibc_pkg::CFG_SLEEP_SECONDS: cfg_q.sleep_seconds <= cfg_data;
				dibc_pkg::CFG_BRIGHT_FILE:   cfg_q.brightness_file_present <= cfg_data[0];
				dibc_pkg::CFG_MAX_BRIGHT:
					cfg_q.max_brightness <= cfg_data[dibc_pkg::LEVEL_W-1:0];
				dibc_pkg::CFG_PANEL_BLANK:   cfg_q.panel_blank_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/dibc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dibc_core
// screen state, idle counter and saved level; with fire high, one event word per cycle
// ----------------------------------------------------------------------------
module dibc_core #(
	parameter int TIMEOUT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  dibc_pkg::cfg_t    cfg,
	input  dibc_pkg::item_t   item,
	output dibc_pkg::result_t result
);

	localparam int CW = TIMEOUT_BITS + 1;

	dibc_pkg::scr_state_t             state_q;
	logic [CW-1:0]                    elapsed_q;
	logic [dibc_pkg::LEVEL_W-1:0]     saved_b_q;
	logic                             saved_v_q;

	dibc_pkg::scr_state_t             st;
	logic [CW-1:0]                    el;
	logic [dibc_pkg::LEVEL_W-1:0]     sb;
	logic                             sv;
	dibc_pkg::result_t                r;
	logic [TIMEOUT_BITS-1:0]          tmo;
	logic [CW-1:0]                    tmo_ext;
	logic                             do_wake;
	logic                             is_toggle;

	assign tmo     = TIMEOUT_BITS'(cfg.sleep_seconds);
	assign tmo_ext = CW'(tmo);

	always_comb begin
		st        = state_q;
		el        = elapsed_q;
		sb        = saved_b_q;
		sv        = saved_v_q;
		r         = '0;
		r.panel_cmd = dibc_pkg::PANEL_NONE;
		is_toggle = (item.mode == dibc_pkg::MODE_TOGGLE);
		do_wake   = (item.mode == dibc_pkg::MODE_ACTIVITY) ||
		            (is_toggle && state_q != dibc_pkg::SCR_ON);

		if (item.mode == dibc_pkg::MODE_TICK) begin
			if (el != {CW{1'b1}})
				el = el + CW'(1);
			if (tmo > TIMEOUT_BITS'(dibc_pkg::DIM_LEAD) &&
			    el > tmo_ext - CW'(dibc_pkg::DIM_LEAD) && st == dibc_pkg::SCR_ON) begin
				if (cfg.brightness_file_present) begin
					sb = item.setting_present ? item.setting_brightness
					                          : dibc_pkg::DEFAULT_LEVEL;
					sv = 1'b1;
				end else begin
					sb = '0;
					sv = 1'b0;
				end
				st                 = dibc_pkg::SCR_DIM;
				r.brightness_write = 1'b1;
				r.brightness_value = dibc_pkg::DIM_LEVEL;
			end
			if (tmo != '0 && el > tmo_ext &&
			    (st == dibc_pkg::SCR_ON || st == dibc_pkg::SCR_DIM)) begin
				st                 = dibc_pkg::SCR_OFF;
				r.brightness_write = 1'b1;
				r.brightness_value = dibc_pkg::OFF_LEVEL;
				r.run_blank_hook   = 1'b1;
				r.show_lock        = 1'b1;
			end
			if (st == dibc_pkg::SCR_OFF && cfg.panel_blank_enable) begin
				r.panel_cmd = dibc_pkg::PANEL_BLANK;
				st          = dibc_pkg::SCR_BLANKED;
			end
		end else if (do_wake) begin
			el = '0;
			if (st != dibc_pkg::SCR_ON) begin
				if (st == dibc_pkg::SCR_BLANKED) begin
					r.panel_cmd        = dibc_pkg::PANEL_UNBLANK;
					r.run_unblank_hook = 1'b1;
				end
				if (st == dibc_pkg::SCR_BLANKED || st == dibc_pkg::SCR_OFF)
					r.force_redraw = 1'b1;
				if (!(sv && sb > dibc_pkg::DIM_LEVEL)) begin
					sb = (item.setting_present && item.setting_brightness > dibc_pkg::DIM_LEVEL)
					     ? item.setting_brightness : cfg.max_brightness;
					sv = 1'b1;
				end
				r.brightness_write = 1'b1;
				r.brightness_value = sb;
				st                 = dibc_pkg::SCR_ON;
			end
		end else begin
			if (st == dibc_pkg::SCR_ON) begin
				if (cfg.brightness_file_present) begin
					sb = item.setting_present ? item.setting_brightness
					                          : dibc_pkg::DEFAULT_LEVEL;
					sv = 1'b1;
				end else begin
					sb = '0;
					sv = 1'b0;
				end
				st                 = dibc_pkg::SCR_OFF;
				r.brightness_write = 1'b1;
				r.brightness_value = dibc_pkg::OFF_LEVEL;
				r.run_blank_hook   = 1'b1;
			end
			if (st == dibc_pkg::SCR_OFF && cfg.panel_blank_enable) begin
				r.panel_cmd = dibc_pkg::PANEL_BLANK;
				st          = dibc_pkg::SCR_BLANKED;
			end
			if (is_toggle)
				r.show_lock = 1'b1;
		end

		r.display_state = dibc_pkg::state_code(st);
		r.screen_off    = (st == dibc_pkg::SCR_OFF || st == dibc_pkg::SCR_BLANKED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dibc_pkg::SCR_ON;
			elapsed_q <= '0;
			saved_b_q <= '0;
			saved_v_q <= 1'b0;
		end else if (fire) begin
			state_q   <= st;
			elapsed_q <= el;
			saved_b_q <= sb;
			saved_v_q <= sv;
		end
	end

	assign result = r;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("screen state lost its one-hot code");

	a_activity_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == dibc_pkg::MODE_ACTIVITY |=> elapsed_q == '0)
		else $error("activity did not clear the idle count");

	a_wake_on: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == dibc_pkg::MODE_ACTIVITY |=> state_q == dibc_pkg::SCR_ON)
		else $error("activity did not return the screen to on");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q) && $stable(elapsed_q) && $stable(saved_v_q))
		else $error("state moved without an event word");

	a_restore_visible: assert property (@(posedge clk) disable iff (!arst_n)
		fire && r.force_redraw |=> saved_v_q)
		else $error("restore left no saved level");

endmodule

### sv/display_idle_blank_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_idle_blank_controller
// display inactivity controller: on, dim, off and blanked
// ----------------------------------------------------------------------------
// an accepted event word is registered in item_s1, its result word then in res_q
// throughput: one word per cycle while results are taken, a stalled result holds back one event only
// reset: screen on, idle count and saved level cleared, timeout disabled,
//   brightness capture and panel blanking enabled, maximum level 255
// ----------------------------------------------------------------------------
module display_idle_blank_controller #(
	parameter int TIMEOUT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dibc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dibc_pkg::CFG_DATA_W-1:0] cfg_data,
	dibc_in_if.sink                         req,
	dibc_out_if.source                      rsp
);

	dibc_pkg::cfg_t    cfg;
	dibc_pkg::item_t   item_s1;
	logic              valid_s1;
	dibc_pkg::result_t res_comb;
	dibc_pkg::result_t res_q;
	logic              rsp_valid_q;
	logic              advance;
	logic              fire;
	logic              take;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;

	dibc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.mode               <= dibc_pkg::mode_t'(req.mode);
			item_s1.setting_brightness <= req.setting_brightness;
			item_s1.setting_present    <= req.setting_present;
		end
	end

	dibc_core #(
		.TIMEOUT_BITS (TIMEOUT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cfg    (cfg),
		.item   (item_s1),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_comb;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.display_state    = res_q.display_state;
	assign rsp.screen_off       = res_q.screen_off;
	assign rsp.brightness_write = res_q.brightness_write;
	assign rsp.brightness_value = res_q.brightness_value;
	assign rsp.panel_cmd        = res_q.panel_cmd;
	assign rsp.run_blank_hook   = res_q.run_blank_hook;
	assign rsp.run_unblank_hook = res_q.run_unblank_hook;
	assign rsp.show_lock        = res_q.show_lock;
	assign rsp.force_redraw     = res_q.force_redraw;

endmodule

### sim/dibc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dibc_result_checker
// tracks register writes and event words, works out the screen state, level
// and pulses each event should produce, and compares every result word
// against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module dibc_result_checker
	import dibc_pkg::*;
#(
	parameter int TIMEOUT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dibc_in_if                    ev_ch,
	dibc_out_if                   res_ch,
	output int                    fails,
	output int                    outstanding,
	output int                    checked
);

	localparam int CNT_W = TIMEOUT_BITS + 1;

	logic [CFG_DATA_W-1:0] sleep_cfg;
	logic                  file_cfg;
	logic [LEVEL_W-1:0]    max_cfg;
	logic                  blank_cfg;

	logic [1:0]            scr;
	logic [CNT_W-1:0]      idle_count;
	logic [LEVEL_W-1:0]    saved_level;
	logic                  saved_ok;

	result_t               predicted;
	result_t               due_results[$];

	int fail_count  = 0;
	int due_count   = 0;
	int match_count = 0;

	assign fails       = fail_count;
	assign outstanding = due_count;
	assign checked     = match_count;

	function automatic void drive_level(input logic [LEVEL_W-1:0] lvl);
		predicted.brightness_write = 1'b1;
		predicted.brightness_value = lvl;
	endfunction

	function automatic void capture_level(input item_t ev);
		if (file_cfg) begin
			saved_level = ev.setting_present ? ev.setting_brightness : DEFAULT_LEVEL;
			saved_ok    = 1'b1;
		end else begin
			saved_level = '0;
			saved_ok    = 1'b0;
		end
	endfunction

	function automatic void blank_if_off();
		if (scr == CODE_OFF && blank_cfg) begin
			predicted.panel_cmd = PANEL_BLANK;
			scr = CODE_BLANKED;
		end
	endfunction

	function automatic void wake_up(input item_t ev);
		idle_count = '0;
		if (scr != CODE_ON) begin
			if (scr == CODE_BLANKED) begin
				predicted.panel_cmd        = PANEL_UNBLANK;
				predicted.run_unblank_hook = 1'b1;
			end
			if (scr >= CODE_OFF)
				predicted.force_redraw = 1'b1;
			if (!(saved_ok && saved_level > DIM_LEVEL)) begin
				if (ev.setting_present && ev.setting_brightness > DIM_LEVEL)
					saved_level = ev.setting_brightness;
				else
					saved_level = max_cfg;
				saved_ok = 1'b1;
			end
			drive_level(saved_level);
			scr = CODE_ON;
		end
	endfunction

	function automatic void request_blank(input item_t ev);
		if (scr == CODE_ON) begin
			capture_level(ev);
			scr = CODE_OFF;
			drive_level(OFF_LEVEL);
			predicted.run_blank_hook = 1'b1;
		end
		blank_if_off();
	endfunction

	function automatic result_t predict_result(input item_t ev);
		logic [CNT_W-1:0] limit;
		predicted = '0;
		case (ev.mode)
			MODE_TICK: begin
				limit = CNT_W'(sleep_cfg) & ((CNT_W'(1) << TIMEOUT_BITS) - 1'b1);
				if (idle_count != '1)
					idle_count = idle_count + 1'b1;
				if (limit > DIM_LEAD && idle_count > limit - DIM_LEAD && scr == CODE_ON) begin
					capture_level(ev);
					scr = CODE_DIM;
					drive_level(DIM_LEVEL);
				end
				if (limit != 0 && idle_count > limit && scr < CODE_OFF) begin
					scr = CODE_OFF;
					drive_level(OFF_LEVEL);
					predicted.run_blank_hook = 1'b1;
					predicted.show_lock      = 1'b1;
				end
				blank_if_off();
			end
			MODE_ACTIVITY: wake_up(ev);
			MODE_BLANK:    request_blank(ev);
			default: begin
				if (scr == CODE_ON) begin
					request_blank(ev);
					predicted.show_lock = 1'b1;
				end else begin
					wake_up(ev);
				end
			end
		endcase
		predicted.display_state = scr;
		predicted.screen_off    = (scr >= CODE_OFF);
		return predicted;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		item_t   ev;
		if (!arst_n) begin
			sleep_cfg   = '0;
			file_cfg    = 1'b1;
			max_cfg     = DEFAULT_LEVEL;
			blank_cfg   = 1'b1;
			scr         = CODE_ON;
			idle_count  = '0;
			saved_level = '0;
			saved_ok    = 1'b0;
			due_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SLEEP_SECONDS: sleep_cfg = cfg_data;
					CFG_BRIGHT_FILE:   file_cfg  = cfg_data[0];
					CFG_MAX_BRIGHT:    max_cfg   = cfg_data[LEVEL_W-1:0];
					CFG_PANEL_BLANK:   blank_cfg = cfg_data[0];
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result word with nothing outstanding");
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("display_state", want.display_state, res_ch.display_state);
					check_field("screen_off", want.screen_off, res_ch.screen_off);
					check_field("brightness_write", want.brightness_write,
						res_ch.brightness_write);
					check_field("brightness_value", want.brightness_value,
						res_ch.brightness_value);
					check_field("panel_cmd", want.panel_cmd, res_ch.panel_cmd);
					check_field("run_blank_hook", want.run_blank_hook, res_ch.run_blank_hook);
					check_field("run_unblank_hook", want.run_unblank_hook,
						res_ch.run_unblank_hook);
					check_field("show_lock", want.show_lock, res_ch.show_lock);
					check_field("force_redraw", want.force_redraw, res_ch.force_redraw);
					match_count++;
				end
			end
			if (ev_ch.valid && ev_ch.ready) begin
				ev.mode               = mode_t'(ev_ch.mode);
				ev.setting_brightness = ev_ch.setting_brightness;
				ev.setting_present    = ev_ch.setting_present;
				due_results.push_back(predict_result(ev));
			end
		end
		due_count = due_results.size();
	end

endmodule

### sim/display_idle_blank_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_idle_blank_controller_tb
// drives event words through the idle/blank controller under several register
// settings: a directed pass over each state move, then random tick runs
// ending in activity, blank or toggle, channels stalling at random in phases
// 0 and 1, one long output stall per phase; checker compares every result word
// ----------------------------------------------------------------------------
module display_idle_blank_controller_tb;
	import dibc_pkg::*;

	localparam int TIMEOUT_BITS = 16;
	localparam int SETTLE       = 4;
	localparam int HOLD_CYCLES  = 48;
	localparam int QUIET_LIMIT  = 1000;
	localparam int SEG_WORDS    = 106;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dibc_in_if  events_if ();
	dibc_out_if results_if ();

	int fails;
	int outstanding;
	int checked;

	int src_idle_pct  = 11;
	int snk_idle_pct  = 68;
	int hold_reqs     = 0;
	int words_sent    = 0;
	int settings_used = 0;
	int quiet_cycles  = 0;

	display_idle_blank_controller #(
		.TIMEOUT_BITS(TIMEOUT_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (events_if),
		.rsp       (results_if)
	);

	dibc_result_checker #(
		.TIMEOUT_BITS(TIMEOUT_BITS)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.ev_ch       (events_if),
		.res_ch      (results_if),
		.fails       (fails),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (events_if.valid && events_if.ready) ||
			(results_if.valid && results_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("display_idle_blank_controller_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// output side: random stalls, plus a long hold whenever one is requested
	initial begin : result_sink
		int seen;
		seen = 0;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != seen) begin
				seen = hold_reqs;
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			results_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	function automatic logic [LEVEL_W-1:0] pick_level();
		return $urandom_range(1) ? LEVEL_W'($urandom_range(0, 7)) :
			LEVEL_W'($urandom_range(0, 255));
	endfunction

	task automatic send_word(input mode_t m, input logic [LEVEL_W-1:0] lvl, input logic pres);
		while ($urandom_range(99) < src_idle_pct) begin
			events_if.valid <= 1'b0;
			@(negedge clk);
		end
		events_if.valid              <= 1'b1;
		events_if.mode               <= m;
		events_if.setting_brightness <= lvl;
		events_if.setting_present    <= pres;
		@(posedge clk);
		while (!events_if.ready) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		events_if.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic program_settings(input logic [CFG_DATA_W-1:0] secs, input logic file_ok,
		input logic [LEVEL_W-1:0] top, input logic blank_ok);
		write_reg(CFG_SLEEP_SECONDS, secs);
		write_reg(CFG_BRIGHT_FILE, CFG_DATA_W'(file_ok));
		write_reg(CFG_MAX_BRIGHT, CFG_DATA_W'(top));
		write_reg(CFG_PANEL_BLANK, CFG_DATA_W'(blank_ok));
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	initial begin : stimulus
		int                    phase;
		int                    seg;
		int                    s;
		int                    sent;
		int                    run;
		int                    k;
		logic [CFG_DATA_W-1:0] secs;
		logic [LEVEL_W-1:0]    top;

		clk                          = 1'b0;
		arst_n                       = 1'b0;
		cfg_we                       = 1'b0;
		cfg_index                    = CFG_SLEEP_SECONDS;
		cfg_data                     = '0;
		events_if.valid              = 1'b0;
		events_if.mode               = MODE_TICK;
		events_if.setting_brightness = '0;
		events_if.setting_present    = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// settings after reset: no timeout, capture on, max 255, blanking on
		send_word(MODE_ACTIVITY, 8'd0, 1'b0);
		send_word(MODE_TICK, 8'd255, 1'b1);
		send_word(MODE_TOGGLE, 8'd255, 1'b0);
		send_word(MODE_TICK, 8'd0, 1'b1);
		send_word(MODE_BLANK, 8'd0, 1'b1);
		send_word(MODE_ACTIVITY, 8'd0, 1'b0);
		send_word(MODE_BLANK, 8'd3, 1'b1);
		send_word(MODE_TOGGLE, 8'd200, 1'b1);
		settle();

		// dim then off with capture and blanking disabled
		program_settings(16'd3, 1'b0, 8'd0, 1'b0);
		send_word(MODE_TICK, 8'd90, 1'b1);
		send_word(MODE_TICK, 8'd90, 1'b1);
		send_word(MODE_BLANK, 8'd170, 1'b1);
		send_word(MODE_TICK, 8'd0, 1'b0);
		send_word(MODE_TICK, 8'd0, 1'b0);
		send_word(MODE_TICK, 8'd0, 1'b0);
		send_word(MODE_ACTIVITY, 8'd0, 1'b0);
		send_word(MODE_TOGGLE, 8'd0, 1'b0);
		send_word(MODE_TOGGLE, 8'd5, 1'b1);
		settle();

		program_settings(16'd0, 1'b1, 8'd255, 1'b0);
		send_word(MODE_BLANK, 8'd255, 1'b1);
		settle();
		// off state blanks on a tick even with the timeout disabled
		program_settings(16'd0, 1'b1, 8'd255, 1'b1);
		send_word(MODE_TICK, 8'd0, 1'b0);
		settle();
		// unblank still fires with blanking now disabled
		program_settings(16'd0, 1'b1, 8'd255, 1'b0);
		send_word(MODE_ACTIVITY, 8'd6, 1'b1);
		settle();

		program_settings(16'd1, 1'b1, 8'd6, 1'b1);
		send_word(MODE_TICK, 8'd6, 1'b1);
		send_word(MODE_TICK, 8'd6, 1'b1);
		send_word(MODE_ACTIVITY, 8'd6, 1'b1);
		settle();

		program_settings(16'd2, 1'b1, 8'd255, 1'b1);
		send_word(MODE_TICK, 8'd128, 1'b0);
		send_word(MODE_TICK, 8'd128, 1'b0);
		send_word(MODE_TICK, 8'd128, 1'b0);
		settle();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin src_idle_pct = 11; snk_idle_pct = 68; end
				1:       begin src_idle_pct = 68; snk_idle_pct = 11; end
				default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				s = phase * 4 + seg;
				case (s % 6)
					0:       secs = 16'd0;
					1:       secs = 16'd1;
					2:       secs = 16'd2;
					3:       secs = 16'd3;
					4:       secs = 16'hFFFF;
					default: secs = CFG_DATA_W'($urandom_range(4, 10));
				endcase
				case (s % 3)
					0:       top = 8'd0;
					1:       top = 8'd255;
					default: top = LEVEL_W'($urandom_range(0, 255));
				endcase
				settle();
				program_settings(secs, s[0], top, s[1]);
				if (seg == 1)
					hold_reqs <= hold_reqs + 1;
				sent = 0;
				while (sent < SEG_WORDS) begin
					if ($urandom_range(99) < 75) begin
						run = $urandom_range(0, (secs <= 10) ? secs + 3 : 8);
						for (k = 0; k < run; k++)
							send_word(MODE_TICK, pick_level(), 1'($urandom_range(1)));
						send_word(mode_t'($urandom_range(MODE_ACTIVITY, MODE_TOGGLE)),
							pick_level(), 1'($urandom_range(1)));
						sent += run + 1;
					end else begin
						send_word(mode_t'($urandom_range(MODE_TICK, MODE_TOGGLE)),
							pick_level(), 1'($urandom_range(1)));
						sent++;
					end
				end
			end
		end
		settle();

		$display("covered %0d event words under %0d register settings, %0d long output holds",
			words_sent, settings_used, hold_reqs);
		$display("%0d result words checked", checked);
		if (fails == 0)
			$display("display_idle_blank_controller_tb OK");
		else
			$display("display_idle_blank_controller_tb NOT OK");
		$finish;
	end

endmodule
